### design/altpid_pkg.sv
// Shared types, register map and fixed constants of the altitude thrust controller.
`default_nettype none

package altpid_pkg;

    // Signed fixed-point word used by the 32-bit data fields
    typedef logic signed [31:0] t_q32;
    // Configuration register contents (unsigned, 31 bits)
    typedef logic [30:0] t_cfg;
    // Register index taken from the APB word address
    typedef logic [2:0] t_cfg_idx;

    // Register map, word index = byte address / 4
    localparam t_cfg_idx CFG_HEIGHT_GAIN      = 3'd0;
    localparam t_cfg_idx CFG_INTEGRAL_GAIN    = 3'd1;
    localparam t_cfg_idx CFG_CLIMB_RATE_GAIN  = 3'd2;
    localparam t_cfg_idx CFG_MAX_ASCENT_RATE  = 3'd3;
    localparam t_cfg_idx CFG_MAX_DESCENT_RATE = 3'd4;
    localparam t_cfg_idx CFG_VEHICLE_MASS     = 3'd5;
    localparam t_cfg_idx CFG_MIN_MOTOR_THRUST = 3'd6;
    localparam t_cfg_idx CFG_MAX_MOTOR_THRUST = 3'd7;

    // Register reset values
    localparam t_cfg RST_HEIGHT_GAIN      = 31'd0;
    localparam t_cfg RST_INTEGRAL_GAIN    = 31'd0;
    localparam t_cfg RST_CLIMB_RATE_GAIN  = 31'd0;
    localparam t_cfg RST_MAX_ASCENT_RATE  = 31'd6553600;
    localparam t_cfg RST_MAX_DESCENT_RATE = 31'd6553600;
    localparam t_cfg RST_VEHICLE_MASS     = 31'd65536;
    localparam t_cfg RST_MIN_MOTOR_THRUST = 31'd0;
    localparam t_cfg RST_MAX_MOTOR_THRUST = 31'd6553600;

    // 32-bit saturation bounds
    localparam t_q32 S32_MAX = 32'sh7FFF_FFFF;
    localparam t_q32 S32_MIN = 32'sh8000_0000;
    localparam logic signed [35:0] S32_MAX_W = 36'sh0_7FFF_FFFF;
    localparam logic signed [35:0] S32_MIN_W = 36'shF_8000_0000;

    // time step and tilt cosine are always Q1.16
    localparam int UNIT_FRAC = 16;

    // Restoring divider: (|num| << 16) / tilt needs 48 quotient bits
    localparam int DIV_BITS = 48;

    // floor(n / 10) = (n * RECIP_TEN) >> RECIP_SHIFT for any 32-bit n
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // 9.81 in Q8.24, rescaled to the working format at elaboration
    localparam longint GRAVITY_Q24 = 64'sd164584489;

    // Clamp a wide signed sum to 32 bits
    function automatic t_q32 sat_s32(input logic signed [35:0] v);
        if (v > S32_MAX_W) begin
            return S32_MAX;
        end
        if (v < S32_MIN_W) begin
            return S32_MIN;
        end
        return t_q32'(v[31:0]);
    endfunction

    // Magnitude of a 32-bit signed word; the most negative value maps to 2^31
    function automatic logic [31:0] abs_s32(input t_q32 v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

endpackage

`default_nettype wire

### design/altitude_pid_thrust_controller_top.sv
// Altitude thrust controller: height/climb-rate cascade with a shared multiplier and divider.
//
// Input channel: i_in_valid / o_in_ready carry one control tick (targets, estimates,
// feed-forward acceleration, tilt cosine, time step). Output channel: o_out_valid /
// i_out_ready carry the clamped collective thrust and its limit flag.
// Configuration: APB write/read of eight 31-bit registers at byte address 4*i,
// pready tied high; write only while no request is in flight.
// Sequence: a request is taken in the idle state, and the next request is taken only once
// the sequencer has returned to idle after passing on the result. Most of the work is the
// 48-step restoring divider (thrust / tilt cosine); the other steps use the single
// 32x32 multiplier and adders.
// The result sits in an output register: a new request is taken while it waits,
// but the sequencer holds its last step until the receiver has taken the old one.
// Reset: configuration registers return to their defaults, the height-error integrator clears,
// and no result is pending.
`default_nettype none

module altitude_pid_thrust_controller_top #(
    parameter int FRAC_BITS        = 16,
    parameter int INTEGRATOR_WIDTH = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // APB configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // Input request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  altpid_pkg::t_q32     i_target_height,
    input  altpid_pkg::t_q32     i_target_climb_rate,
    input  altpid_pkg::t_q32     i_height,
    input  altpid_pkg::t_q32     i_climb_rate,
    input  altpid_pkg::t_q32     i_accel_feedforward,
    input  logic [16:0]          i_tilt_cosine,
    input  logic [16:0]          i_time_step,
    // Result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output altpid_pkg::t_q32     o_thrust_command,
    output logic                 o_thrust_limited
);
    import altpid_pkg::*;

    localparam int IW    = INTEGRATOR_WIDTH;
    localparam int IWX   = INTEGRATOR_WIDTH + 1;
    localparam int CNT_W = $clog2(DIV_BITS);

    localparam t_q32 GRAVITY_Q =
        t_q32'((((GRAVITY_Q24 <<< 1) >>> (24 - FRAC_BITS)) + 64'sd1) >>> 1);

    // Sequencer states, straight-line steps are numbered in order
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_ERR      = 5'd1;
    localparam logic [4:0] S_ABS_ERR  = 5'd2;
    localparam logic [4:0] S_MUL_INC  = 5'd3;
    localparam logic [4:0] S_INTEG    = 5'd4;
    localparam logic [4:0] S_IMAG     = 5'd5;
    localparam logic [4:0] S_VSUM     = 5'd6;
    localparam logic [4:0] S_VCLAMP   = 5'd7;
    localparam logic [4:0] S_VERR     = 5'd8;
    localparam logic [4:0] S_ABS_VERR = 5'd9;
    localparam logic [4:0] S_KV       = 5'd10;
    localparam logic [4:0] S_KI_ACC   = 5'd11;
    localparam logic [4:0] S_ACCEL    = 5'd12;
    localparam logic [4:0] S_GACC     = 5'd13;
    localparam logic [4:0] S_ABS_G    = 5'd14;
    localparam logic [4:0] S_MUL_M    = 5'd15;
    localparam logic [4:0] S_WAIT_M   = 5'd16;
    localparam logic [4:0] S_NUM      = 5'd17;
    localparam logic [4:0] S_DIV      = 5'd18;
    localparam logic [4:0] S_THRUST   = 5'd19;
    localparam logic [4:0] S_BOUNDS   = 5'd20;
    localparam logic [4:0] S_DONE     = 5'd21;

    // Fixed-point product scale-back: truncate toward zero, saturate to 32 bits
    function automatic t_q32 mul_post(input logic [63:0] p, input logic neg);
        logic [63:0] q;
        q = p >> FRAC_BITS;
        if (|q[63:31]) begin
            return neg ? S32_MIN : S32_MAX;
        end
        return neg ? -t_q32'({1'b0, q[30:0]}) : t_q32'({1'b0, q[30:0]});
    endfunction

    // Control state
    logic [4:0]           r_state;
    logic [4:0]           n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_out_valid;
    logic signed [IW-1:0] r_integ;

    // Configuration registers
    t_cfg r_kp, r_ki, r_kv, r_asc, r_desc, r_mass, r_tmin, r_tmax;

    // Latched request fields
    t_q32        r_th, r_h, r_tcr, r_cr, r_aff;
    logic [16:0] r_tilt, r_dt;

    // Datapath
    t_q32              r_err, r_vcmd, r_verr, r_accel, r_gma, r_mq;
    t_q32              r_thrust, r_margin, r_lo, r_hi;
    t_q32              r_thrust_out;
    logic              r_limited;
    logic signed [33:0] r_acc;
    logic [31:0]       r_opb;
    logic              r_pneg, r_neg, r_dneg;
    logic [63:0]       r_prod, r_hold, r_imag;
    logic [DIV_BITS-1:0] r_dvd;
    logic [16:0]       r_rem;

    // Combinational helpers
    logic [31:0]          mul_a, mul_b;
    logic [63:0]          mul_p;
    logic                 cfg_wr;
    logic                 done_fire;
    logic signed [IWX-1:0] integ_ext, inc_ext, integ_sum;
    logic signed [IW-1:0] integ_sat;
    logic [IW-1:0]        integ_mag;
    logic [17:0]          div_trial;
    logic                 div_ge;
    t_q32                 span;

    assign pready      = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_thrust_command = r_thrust_out;
    assign o_thrust_limited = r_limited;

    assign cfg_wr    = psel & penable & pwrite & pready;
    assign done_fire = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Register read-back
    always_comb begin
        case (paddr[4:2])
            CFG_HEIGHT_GAIN:      prdata = {1'b0, r_kp};
            CFG_INTEGRAL_GAIN:    prdata = {1'b0, r_ki};
            CFG_CLIMB_RATE_GAIN:  prdata = {1'b0, r_kv};
            CFG_MAX_ASCENT_RATE:  prdata = {1'b0, r_asc};
            CFG_MAX_DESCENT_RATE: prdata = {1'b0, r_desc};
            CFG_VEHICLE_MASS:     prdata = {1'b0, r_mass};
            CFG_MIN_MOTOR_THRUST: prdata = {1'b0, r_tmin};
            CFG_MAX_MOTOR_THRUST: prdata = {1'b0, r_tmax};
            default:              prdata = '0;
        endcase
    end

    // Shared multiplier operand select; the default pair feeds the divide-by-ten
    always_comb begin
        mul_a = r_opb;
        mul_b = RECIP_TEN;
        case (r_state)
            S_MUL_INC:  mul_b = 32'(r_dt);
            S_INTEG:    mul_b = 32'(r_kp);
            S_VERR: begin
                mul_a = r_imag[31:0];
                mul_b = 32'(r_ki);
            end
            S_ABS_VERR: begin
                mul_a = r_imag[63:32];
                mul_b = 32'(r_ki);
            end
            S_KV:       mul_b = 32'(r_kv);
            S_MUL_M:    mul_b = 32'(r_mass);
            default: ;
        endcase
    end

    assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

    // Integrator step: add or subtract |err*dt| >> 16, saturate to IW bits
    assign integ_ext = {r_integ[IW-1], r_integ};
    assign inc_ext   = IWX'(r_prod[UNIT_FRAC +: 32]);
    assign integ_sum = r_err[31] ? (integ_ext - inc_ext) : (integ_ext + inc_ext);

    always_comb begin
        if (integ_sum[IW] != integ_sum[IW-1]) begin
            integ_sat = integ_sum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
        end else begin
            integ_sat = integ_sum[IW-1:0];
        end
    end

    assign integ_mag = r_integ[IW-1] ? IW'(-r_integ) : IW'(r_integ);

    // Restoring divider step
    assign div_trial = {r_rem, r_dvd[DIV_BITS-1]};
    assign div_ge    = (div_trial >= {1'b0, r_tilt});

    // Motor range span for the margin
    assign span = t_q32'({1'b0, r_tmax}) - t_q32'({1'b0, r_tmin});

    // Sequencer next state
    always_comb begin
        case (r_state)
            S_IDLE:   n_state = i_in_valid ? S_ERR : S_IDLE;
            S_DIV:    n_state = (r_cnt == '0) ? S_THRUST : S_DIV;
            S_DONE:   n_state = done_fire ? S_IDLE : S_DONE;
            default:  n_state = (r_state >= S_DONE) ? S_IDLE : r_state + 5'd1;
        endcase
    end

    // Control registers: state, result valid, integrator, configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_integ     <= '0;
            r_kp        <= RST_HEIGHT_GAIN;
            r_ki        <= RST_INTEGRAL_GAIN;
            r_kv        <= RST_CLIMB_RATE_GAIN;
            r_asc       <= RST_MAX_ASCENT_RATE;
            r_desc      <= RST_MAX_DESCENT_RATE;
            r_mass      <= RST_VEHICLE_MASS;
            r_tmin      <= RST_MIN_MOTOR_THRUST;
            r_tmax      <= RST_MAX_MOTOR_THRUST;
        end else begin
            r_state <= n_state;

            if (done_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (r_state == S_INTEG) begin
                r_integ <= integ_sat;
            end

            if (cfg_wr) begin
                case (paddr[4:2])
                    CFG_HEIGHT_GAIN:      r_kp   <= pwdata[30:0];
                    CFG_INTEGRAL_GAIN:    r_ki   <= pwdata[30:0];
                    CFG_CLIMB_RATE_GAIN:  r_kv   <= pwdata[30:0];
                    CFG_MAX_ASCENT_RATE:  r_asc  <= pwdata[30:0];
                    CFG_MAX_DESCENT_RATE: r_desc <= pwdata[30:0];
                    CFG_VEHICLE_MASS:     r_mass <= pwdata[30:0];
                    CFG_MIN_MOTOR_THRUST: r_tmin <= pwdata[30:0];
                    CFG_MAX_MOTOR_THRUST: r_tmax <= pwdata[30:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        // Multiplier and scale-back run every cycle; steps pick them up when needed
        r_prod <= mul_p;
        r_mq   <= mul_post(r_prod, r_pneg);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_th   <= i_target_height;
                    r_tcr  <= i_target_climb_rate;
                    r_h    <= i_height;
                    r_cr   <= i_climb_rate;
                    r_aff  <= i_accel_feedforward;
                    r_tilt <= (i_tilt_cosine == '0) ? 17'd1 : i_tilt_cosine;
                    r_dt   <= i_time_step;
                end
            end
            // height error
            S_ERR:      r_err <= sat_s32(36'(r_th) - 36'(r_h));
            S_ABS_ERR:  r_opb <= abs_s32(r_err);
            // kp * err launched while the integrator updates
            S_INTEG:    r_pneg <= r_err[31];
            S_IMAG:     r_imag <= 64'(integ_mag);
            // climb-rate command and its limits
            S_VSUM:     r_vcmd <= sat_s32(36'(r_tcr) + 36'(r_mq));
            S_VCLAMP: begin
                if (r_vcmd < -t_q32'({1'b0, r_asc})) begin
                    r_vcmd <= -t_q32'({1'b0, r_asc});
                end else if (r_vcmd > t_q32'({1'b0, r_desc})) begin
                    r_vcmd <= t_q32'({1'b0, r_desc});
                end
            end
            S_VERR:     r_verr <= sat_s32(36'(r_vcmd) - 36'(r_cr));
            S_ABS_VERR: begin
                r_opb  <= abs_s32(r_verr);
                r_hold <= r_prod;
            end
            // ki * integrator is two 32-bit partial products, kept modulo 2^64
            S_KV: begin
                r_hold <= r_hold + {r_prod[31:0], 32'b0};
                r_pneg <= r_verr[31];
            end
            S_KI_ACC:   r_acc <= 34'(r_aff) + 34'(mul_post(r_hold, r_integ[IW-1]));
            S_ACCEL:    r_accel <= sat_s32(36'(r_acc) + 36'(r_mq));
            S_GACC:     r_gma <= sat_s32(36'(GRAVITY_Q) - 36'(r_accel));
            S_ABS_G:    r_opb <= abs_s32(r_gma);
            S_MUL_M:    r_pneg <= r_gma[31];
            // set up the divider and the margin product
            S_NUM: begin
                r_dvd  <= {abs_s32(r_mq), {UNIT_FRAC{1'b0}}};
                r_rem  <= '0;
                r_neg  <= r_mq[31];
                r_cnt  <= CNT_W'(DIV_BITS - 1);
                r_dneg <= span[31];
                r_opb  <= abs_s32(span);
            end
            S_DIV: begin
                if (div_ge) begin
                    r_rem <= 17'(div_trial - {1'b0, r_tilt});
                end else begin
                    r_rem <= div_trial[16:0];
                end
                r_dvd <= {r_dvd[DIV_BITS-2:0], div_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            // signed, saturated quotient; margin = span / 10 toward zero
            S_THRUST: begin
                if (|r_dvd[DIV_BITS-1:31]) begin
                    r_thrust <= r_neg ? S32_MIN : S32_MAX;
                end else begin
                    r_thrust <= r_neg ? -t_q32'({1'b0, r_dvd[30:0]})
                                      : t_q32'({1'b0, r_dvd[30:0]});
                end
                r_margin <= r_dneg ? -t_q32'(32'(r_prod[63:RECIP_SHIFT]))
                                   : t_q32'(32'(r_prod[63:RECIP_SHIFT]));
            end
            // four-motor limits with the margin removed on each side
            S_BOUNDS: begin
                r_lo <= sat_s32((36'(t_q32'({1'b0, r_tmin})) + 36'(r_margin)) <<< 2);
                r_hi <= sat_s32((36'(t_q32'({1'b0, r_tmax})) - 36'(r_margin)) <<< 2);
            end
            // low limit tested first: when inverted, thrust below it gets the low limit, else the high
            S_DONE: begin
                if (done_fire) begin
                    if (r_thrust < r_lo) begin
                        r_thrust_out <= r_lo;
                        r_limited    <= 1'b1;
                    end else if (r_thrust > r_hi) begin
                        r_thrust_out <= r_hi;
                        r_limited    <= 1'b1;
                    end else begin
                        r_thrust_out <= r_thrust;
                        r_limited    <= 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire
